// ===== src/cht_pkg.sv =====
// Package for the compass heading tracker: payload structs, FSM states,
// CORDIC arctangent table and degree conversion constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cht_pkg;

  // Fixed field widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned DIFF_W   = SAMPLE_W + 1;
  localparam int unsigned PRESCALE = 16;
  // CORDIC datapath width: 17-bit difference, 16-bit prescale, gain and headroom
  localparam int unsigned XY_W     = 36;
  localparam int unsigned ANGLE_W  = 32;

  // Heading format and full-turn constant
  localparam int unsigned HEADING_FRAC_BITS = 7;
  localparam int unsigned HEADING_FULL      = 360 << HEADING_FRAC_BITS;
  localparam int unsigned FULL_W            = $clog2(HEADING_FULL + 1);
  localparam logic [FULL_W-1:0] HEADING_FULL_V = FULL_W'(HEADING_FULL);

  // CORDIC iteration count and table size
  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned ATAN_ENTRIES     = 24;
  localparam int unsigned ATAN_IDX_W       = 5;

  // Configuration register indices
  typedef enum logic {
    CFG_OFFSET_X = 1'b0,
    CFG_OFFSET_Y = 1'b1
  } cht_cfg_idx_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ITER,
    ST_MUL,
    ST_RND
  } cht_state_e;

  // Input transaction payload
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] field_x;
    logic signed [SAMPLE_W-1:0] field_y;
  } cht_in_t;

  // Output transaction payload
  typedef struct packed {
    logic        [SAMPLE_W-1:0] heading_deg;
    logic signed [SAMPLE_W-1:0] min_x;
    logic signed [SAMPLE_W-1:0] max_x;
    logic signed [SAMPLE_W-1:0] min_y;
    logic signed [SAMPLE_W-1:0] max_y;
  } cht_out_t;

  // Sequencer commands to the CORDIC unit
  typedef struct packed {
    logic load;
    logic advance;
  } cht_cordic_ctrl_t;

  // atan(2^-i) in binary angle units, 2^32 = one full turn
  function automatic logic [ANGLE_W-1:0] cht_atan(input logic [ATAN_IDX_W-1:0] idx);
    logic [ANGLE_W-1:0] v;
    case (idx)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== src/compass_heading_tracker_unit.sv =====
// Top level of the compass heading tracker: calibration extremes, offsets,
// sequencer, degree conversion and output register.
// Depends on cht_pkg and cht_cordic.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------
//  in      | in        | in_valid_i/in_stall_o | in_data_i  (cht_in_t)
//  out     | out       | out_valid_o/out_stall_i | out_data_o (cht_out_t)
//  cfg     | in        | cfg_we_i              | cfg_idx_i, cfg_wdata_i
//
// An item passes through these steps, N = min(CORDIC_STEPS, 24): load the
// CORDIC, N iterations of the shared shift-add unit, one multiply, one round.
// Reset clears the extremes to their empty values and the offsets to zero.
// A stalled result holds in the output register; the next sample is taken
// meanwhile, and only the round stage waits for the register to free up.
`timescale 1ns / 1ps
`default_nettype none

module compass_heading_tracker_unit
  import cht_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire cht_in_t             in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output cht_out_t                 out_data_o,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_idx_i,
  input  wire logic [SAMPLE_W-1:0] cfg_wdata_i
);

  localparam int unsigned STEPS_EFF = (CORDIC_STEPS < ATAN_ENTRIES) ?
                                      CORDIC_STEPS : ATAN_ENTRIES;
  localparam int unsigned STEP_W    = $clog2(STEPS_EFF);
  localparam int unsigned PROD_W    = ANGLE_W + FULL_W;

  cht_state_e state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  logic signed [SAMPLE_W-1:0] offx_q, offy_q;
  logic signed [SAMPLE_W-1:0] low_x_q, high_x_q, low_y_q, high_y_q;
  logic zero_q;
  logic [PROD_W-1:0] prod_q;
  logic out_valid_q;
  cht_out_t out_data_q;

  logic in_accept, out_load;
  logic signed [DIFF_W-1:0] dx, dy;
  cht_cordic_ctrl_t cordic_ctrl;
  logic [ANGLE_W-1:0] z;
  logic [PROD_W:0] rounded;
  logic [FULL_W:0] deg;
  logic [SAMPLE_W-1:0] heading;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // Offset-corrected differences, exact in 17 bits
  assign dx = DIFF_W'(in_data_i.field_x) - DIFF_W'(offx_q);
  assign dy = DIFF_W'(in_data_i.field_y) - DIFF_W'(offy_q);

  // Sequencer: next state and CORDIC commands
  always_comb begin
    state_d             = state_q;
    step_d              = step_q;
    cordic_ctrl.load    = 1'b0;
    cordic_ctrl.advance = 1'b0;
    out_load            = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          cordic_ctrl.load = 1'b1;
          step_d           = '0;
          state_d          = ST_ITER;
        end
      end
      ST_ITER: begin
        cordic_ctrl.advance = 1'b1;
        step_d              = step_q + 1'b1;
        if (step_q == STEP_W'(STEPS_EFF - 1)) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_RND;
      end
      ST_RND: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Shared CORDIC unit
  cht_cordic #(
    .STEP_W (STEP_W)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (cordic_ctrl),
    .dx_i   (dx),
    .dy_i   (dy),
    .step_i (step_q),
    .z_o    (z)
  );

  // Write the hard-iron offsets
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offx_q <= '0;
      offy_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cht_cfg_idx_e'(cfg_idx_i))
        CFG_OFFSET_X: offx_q <= cfg_wdata_i;
        CFG_OFFSET_Y: offy_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Advance the calibration extremes on each accepted sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_x_q  <= 16'sh7FFF;
      high_x_q <= 16'sh8000;
      low_y_q  <= 16'sh7FFF;
      high_y_q <= 16'sh8000;
      zero_q   <= 1'b0;
    end else if (in_accept) begin
      if (in_data_i.field_x < low_x_q)  low_x_q  <= in_data_i.field_x;
      if (in_data_i.field_x > high_x_q) high_x_q <= in_data_i.field_x;
      if (in_data_i.field_y < low_y_q)  low_y_q  <= in_data_i.field_y;
      if (in_data_i.field_y > high_y_q) high_y_q <= in_data_i.field_y;
      zero_q <= (dx == '0) && (dy == '0);
    end
  end

  // Scale the binary angle to degrees
  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL) begin
      prod_q <= z * HEADING_FULL_V;
    end
  end

  // Round half up, wrap a full turn to zero, report zero for the zero vector
  assign rounded = {1'b0, prod_q} + (PROD_W + 1)'(64'h80000000);
  assign deg     = rounded[PROD_W:ANGLE_W];
  always_comb begin
    if (zero_q || (deg >= (FULL_W + 1)'(HEADING_FULL))) begin
      heading = '0;
    end else begin
      heading = SAMPLE_W'(deg);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.heading_deg <= heading;
      out_data_q.min_x       <= low_x_q;
      out_data_q.max_x       <= high_x_q;
      out_data_q.min_y       <= low_y_q;
      out_data_q.max_y       <= high_y_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== src/cht_cordic.sv =====
// Vectoring CORDIC for the compass heading tracker: one shift-add-compare
// iteration per advance, angle accumulated in binary angle units.
// Depends on cht_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cht_cordic
  import cht_pkg::*;
#(
  parameter int unsigned STEP_W = $clog2(CORDIC_STEPS_DEF)
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire cht_cordic_ctrl_t           ctrl_i,
  input  wire logic signed [DIFF_W-1:0]   dx_i,
  input  wire logic signed [DIFF_W-1:0]   dy_i,
  input  wire logic        [STEP_W-1:0]   step_i,
  output logic             [ANGLE_W-1:0]  z_o
);

  logic signed [XY_W-1:0]   x_q, x_d, y_q, y_d;
  logic        [ANGLE_W-1:0] z_q, z_d;
  logic signed [XY_W-1:0]   dx_w, dy_w, xs, ys;
  logic        [ANGLE_W-1:0] atan_v;

  // Prescaled differences for the initial vector
  assign dx_w = XY_W'(dx_i) <<< PRESCALE;
  assign dy_w = XY_W'(dy_i) <<< PRESCALE;

  // Shared shifter and table lookup for the current iteration
  assign xs     = x_q >>> step_i;
  assign ys     = y_q >>> step_i;
  assign atan_v = cht_atan(ATAN_IDX_W'(step_i));

  // Load the start vector or rotate it one step towards the x axis
  always_comb begin
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    if (ctrl_i.load) begin
      if (dx_i < 0) begin
        x_d = -dx_w;
        y_d = -dy_w;
        z_d = 32'h80000000;
      end else begin
        x_d = dx_w;
        y_d = dy_w;
        z_d = '0;
      end
    end else if (ctrl_i.advance) begin
      if (!y_q[XY_W-1]) begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + atan_v;
      end else begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - atan_v;
      end
    end
  end

  // Hold the vector and angle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      y_q <= '0;
      z_q <= '0;
    end else begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign z_o = z_q;

endmodule

`default_nettype wire

// ===== src/cht_checker.sv =====
// Port-level checks for the compass heading tracker, bound to the top level.
// Depends on cht_pkg and compass_heading_tracker_unit.
`timescale 1ns / 1ps
`default_nettype none

module cht_checker
  import cht_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire cht_out_t            out_data_o
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // An accepted sample keeps the input stalled while it is worked on
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after a transaction");

  // Reported extremes include the sample, so they never cross
  a_extremes_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.min_x <= out_data_o.max_x) &&
                    (out_data_o.min_y <= out_data_o.max_y))
    else $error("minimum above maximum");

  // Heading stays below a full turn
  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.heading_deg < SAMPLE_W'(HEADING_FULL)))
    else $error("heading out of range");

endmodule

bind compass_heading_tracker_unit cht_checker u_cht_checker (.*);

`default_nettype wire
